FILE: rtl/scda_pkg.sv
// scda_pkg: shared types, codes and constants for the scaled calendar day advancer
// used by every rtl file but scda_chk; depends on nothing
package scda_pkg;

  localparam int unsigned FRACTION_BITS_DEF = 16;
  localparam int unsigned MAX_RESULTS       = 64;
  localparam int unsigned CNT_W             = 7;   // holds 0..MAX_RESULTS
  localparam int unsigned ELAPSED_W         = 19;
  localparam int unsigned SPEED_W           = 3;
  localparam int unsigned MAX_SHIFT_W       = 3;   // rate shift is at most 3

  localparam logic [13:0] YEAR_MIN      = 14'd1;
  localparam logic [13:0] YEAR_MAX      = 14'd9999;
  localparam logic [13:0] START_YEAR_RST  = 14'd1836;
  localparam logic [3:0]  START_MONTH_RST = 4'd1;
  localparam logic [4:0]  START_DAY_RST   = 5'd1;

  // year / 100 as (year * 5243) >> 19, exact for any 14-bit year
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int unsigned DIV100_SHIFT = 19;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_SPEED  = 2'd1;
  localparam logic [1:0] MODE_RESUME = 2'd2;

  localparam logic [2:0] SPEED_PAUSED  = 3'd0;
  localparam logic [2:0] SPEED_SLOW    = 3'd1;
  localparam logic [2:0] SPEED_FASTEST = 3'd4;

  localparam logic [1:0] REG_START_YEAR  = 2'd0;
  localparam logic [1:0] REG_START_MONTH = 2'd1;
  localparam logic [1:0] REG_START_DAY   = 2'd2;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  // what the date step unit hands back to the sequencer
  typedef struct packed {
    date_t       nxt;
    logic [6:0]  mod100_nxt;
    logic [1:0]  cent4_nxt;
    logic [4:0]  mlen;
    logic        mc;
    logic        yc;
    logic        at_end;
    logic        next_end;
  } step_t;

  // start-date registers as seen by the sequencer
  typedef struct packed {
    date_t start;
    logic  load;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_LD_DIV,
    ST_LD_MOD,
    ST_LD_DAY,
    ST_IDLE,
    ST_RUN
  } state_t;

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    case (m)
      4'd2:                   d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      default:                d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/scaled_calendar_day_advancer.sv
// scaled_calendar_day_advancer: top level, sequencer, day accumulator and output register
// depends on scda_pkg, scda_cfg, scda_date_step
//
//  channel  dir  handshake              payload
//  s_*      in   s_tvalid / s_tready    s_tuser = mode, s_tdata = elapsed_time, new_speed
//  m_*      out  m_tvalid / m_tready    m_tdata = year, month, day; m_tuser = month/year
//                                       change; m_tlast = last day of the tick
//  apb      in   psel & penable         start_year @0x0, start_month @0x4, start_day @0x8
//
// a tick emits one day per cycle through the shared date step unit while m_tready
// does not stall the output register; a tick emits at most 64 days
// speed change, resume and ticks with zero days finish in the accept cycle
// after reset and after each start-date write a load (divide by 100, remainder,
// day clamp, in that order) runs with s_tready low
// a stalled m_tready holds the date sequencer; the next word is taken while the
// final day still waits in the output register
module scaled_calendar_day_advancer import scda_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // apb configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // elapsed_time[18:0], new_speed[21:19], zero pad
  input  logic [1:0]  s_tuser,   // mode[1:0]
  // day results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // year[13:0], month[17:14], day[22:18], zero pad
  output logic [1:0]  m_tuser,   // month_changed[0], year_changed[1]
  output logic        m_tlast    // last_day
);

  // accumulator sum: fraction plus elapsed time shifted by up to three
  localparam int unsigned TOT_W  = FRACTION_BITS + ELAPSED_W + MAX_SHIFT_W + 1;
  localparam int unsigned DAYS_W = TOT_W - FRACTION_BITS;

  cfg_t   cfg;
  step_t  step;
  state_t state, state_next;

  // calendar state
  date_t       cur;
  logic [6:0]  mod100;   // year mod 100
  logic [1:0]  cent4;    // (year / 100) mod 4
  logic [6:0]  yq;       // year / 100 during the load
  logic [FRACTION_BITS-1:0] frac, frac_next;
  logic [CNT_W-1:0]         cnt, cnt_next;
  logic [SPEED_W-1:0]       speed_now, speed_before_pause;

  // input word fields
  logic [1:0]           in_mode;
  logic [ELAPSED_W-1:0] in_elapsed;
  logic [SPEED_W-1:0]   in_speed;

  logic                 in_take, emit, speed_ok;
  logic [1:0]           shift;
  logic [TOT_W-1:0]     total;
  logic [DAYS_W-1:0]    days;
  logic [26:0]          div_prod;
  logic [13:0]          y_cl;
  logic [3:0]           m_cl;

  assign in_mode    = s_tuser;
  assign in_elapsed = s_tdata[18:0];
  assign in_speed   = s_tdata[21:19];

  scda_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // the one date unit serves both the day clamp at load and every day step
  scda_date_step u_step (
    .cur    (cur),
    .mod100 (mod100),
    .cent4  (cent4),
    .step   (step)
  );

  // start date clamps
  always_comb begin
    if (cfg.start.year < YEAR_MIN)      y_cl = YEAR_MIN;
    else if (cfg.start.year > YEAR_MAX) y_cl = YEAR_MAX;
    else                                y_cl = cfg.start.year;
    if (cfg.start.month < MONTH_JAN)      m_cl = MONTH_JAN;
    else if (cfg.start.month > MONTH_DEC) m_cl = MONTH_DEC;
    else                                  m_cl = cfg.start.month;
    div_prod = 27'(y_cl) * 27'(DIV100_MUL);
  end

  // tick accumulation: fraction plus scaled elapsed time, whole days capped
  always_comb begin
    speed_ok  = (speed_now >= SPEED_SLOW) && (speed_now <= SPEED_FASTEST);
    shift     = 2'(speed_now - SPEED_SLOW);
    total     = TOT_W'(frac) + (TOT_W'(in_elapsed) << shift);
    days      = total[TOT_W-1:FRACTION_BITS];
    frac_next = total[FRACTION_BITS-1:0];
    if (days > DAYS_W'(MAX_RESULTS)) cnt_next = CNT_W'(MAX_RESULTS);
    else                             cnt_next = days[CNT_W-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LD_DIV: state_next = ST_LD_MOD;
      ST_LD_MOD: state_next = ST_LD_DAY;
      ST_LD_DAY: state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_take && (in_mode == MODE_TICK) && speed_ok && (cnt_next != '0))
          state_next = ST_RUN;
      end
      ST_RUN: begin
        if ((cnt == '0) || step.at_end) state_next = ST_IDLE;
      end
      default: state_next = ST_LD_DIV;
    endcase
    if (cfg.load) state_next = ST_LD_DIV;
  end

  // sequencer outputs
  always_comb begin
    s_tready = (state == ST_IDLE) && !cfg.load;
    in_take  = s_tvalid && s_tready;
    emit     = (state == ST_RUN) && (cnt != '0) && !step.at_end &&
               (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LD_DIV;
    end else begin
      state <= state_next;
    end
  end

  // speed state
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_now          <= SPEED_PAUSED;
      speed_before_pause <= SPEED_SLOW;
    end else if (in_take) begin
      case (in_mode)
        MODE_SPEED: begin
          if (in_speed != speed_now) begin
            if (speed_now != SPEED_PAUSED) speed_before_pause <= speed_now;
            speed_now <= in_speed;
          end
        end
        MODE_RESUME: begin
          // paused speed is never remembered, so this is a real change
          if (speed_now == SPEED_PAUSED) speed_now <= speed_before_pause;
        end
        default: ;
      endcase
    end
  end

  // fraction and day count
  always_ff @(posedge clk) begin
    if (rst) begin
      frac <= '0;
      cnt  <= '0;
    end else if (state == ST_LD_DIV) begin
      frac <= '0;
      cnt  <= '0;
    end else if (in_take && (in_mode == MODE_TICK) && speed_ok) begin
      frac <= frac_next;
      cnt  <= cnt_next;
    end else if (emit) begin
      cnt  <= cnt - CNT_W'(1);
    end
  end

  // calendar registers: load sequence, then one day per emitted word
  always_ff @(posedge clk) begin
    case (state)
      ST_LD_DIV: begin
        cur.year  <= y_cl;
        cur.month <= m_cl;
        cur.day   <= 5'd1;
        yq        <= div_prod[DIV100_SHIFT+6:DIV100_SHIFT];
      end
      ST_LD_MOD: begin
        mod100 <= 7'(cur.year - 14'(yq) * 14'd100);
        cent4  <= yq[1:0];
      end
      ST_LD_DAY: begin
        if (cfg.start.day < 5'd1)            cur.day <= 5'd1;
        else if (cfg.start.day > step.mlen)  cur.day <= step.mlen;
        else                                 cur.day <= cfg.start.day;
      end
      ST_RUN: begin
        if (emit) begin
          cur    <= step.nxt;
          mod100 <= step.mod100_nxt;
          cent4  <= step.cent4_nxt;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {1'b0, step.nxt.day, step.nxt.month, step.nxt.year};
      m_tuser <= {step.yc, step.mc};
      // the final day of a tick, or the day that reaches the end of the calendar
      m_tlast <= (cnt == CNT_W'(1)) || step.next_end;
    end
  end

endmodule

FILE: rtl/scda_date_step.sv
// scda_date_step: shared date unit, month length and next-day computation
// depends on scda_pkg
module scda_date_step import scda_pkg::*; (
  input  date_t       cur,
  input  logic [6:0]  mod100,
  input  logic [1:0]  cent4,
  output step_t       step
);

  logic leap;

  always_comb begin
    leap = ((cur.year[1:0] == 2'd0) && (mod100 != 7'd0)) ||
           ((mod100 == 7'd0) && (cent4 == 2'd0));
    step.mlen       = month_days(cur.month, leap);
    step.at_end     = (cur.year == YEAR_MAX) && (cur.month == MONTH_DEC) &&
                      (cur.day == 5'd31);
    step.nxt        = cur;
    step.mod100_nxt = mod100;
    step.cent4_nxt  = cent4;
    step.mc         = 1'b0;
    step.yc         = 1'b0;
    if (cur.day < step.mlen) begin
      step.nxt.day = cur.day + 5'd1;
    end else begin
      step.nxt.day = 5'd1;
      step.mc      = 1'b1;
      if (cur.month < MONTH_DEC) begin
        step.nxt.month = cur.month + 4'd1;
      end else begin
        step.nxt.month = MONTH_JAN;
        step.nxt.year  = cur.year + 14'd1;
        step.yc        = 1'b1;
        if (mod100 == 7'd99) begin
          step.mod100_nxt = 7'd0;
          step.cent4_nxt  = cent4 + 2'd1;
        end else begin
          step.mod100_nxt = mod100 + 7'd1;
        end
      end
    end
    step.next_end = (step.nxt.year == YEAR_MAX) && (step.nxt.month == MONTH_DEC) &&
                    (step.nxt.day == 5'd31);
  end

endmodule

FILE: rtl/scda_cfg.sv
// scda_cfg: apb register file for the start date, flags a load on each start-date write
// depends on scda_pkg
module scda_cfg import scda_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  date_t start;
  logic  wr;
  logic  hit;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      REG_START_YEAR:  hit = 1'b1;
      REG_START_MONTH: hit = 1'b1;
      REG_START_DAY:   hit = 1'b1;
      default:         hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start.year  <= START_YEAR_RST;
      start.month <= START_MONTH_RST;
      start.day   <= START_DAY_RST;
    end else if (wr) begin
      case (paddr[3:2])
        REG_START_YEAR:  start.year  <= pwdata[13:0];
        REG_START_MONTH: start.month <= pwdata[3:0];
        REG_START_DAY:   start.day   <= pwdata[4:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_START_YEAR:  prdata = {18'd0, start.year};
      REG_START_MONTH: prdata = {28'd0, start.month};
      REG_START_DAY:   prdata = {27'd0, start.day};
      default:         prdata = 32'd0;
    endcase
  end

  assign cfg.start = start;
  assign cfg.load  = wr && hit;

endmodule

FILE: rtl/scda_chk.sv
// scda_chk: port-level checker for the scaled calendar day advancer, bound to the top
// depends on scaled_calendar_day_advancer port names
module scda_chk (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // a stalled day word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
      $stable(m_tlast))
    else $error("stalled day word changed");

  // emitted dates are in range
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[17:14] != 4'd0) && (m_tdata[17:14] <= 4'd12) &&
      (m_tdata[22:18] != 5'd0) && (m_tdata[13:0] != 14'd0) && (m_tdata[13:0] <= 14'd9999))
    else $error("day word out of calendar range");

  // a month change lands on the first of the month
  a_month: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata[22:18] == 5'd1))
    else $error("month change not on day one");

  // a year change is a month change into january
  a_year: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tuser[0] && (m_tdata[17:14] == 4'd1))
    else $error("year change not on january first");

endmodule

bind scaled_calendar_day_advancer scda_chk u_scda_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
